### design/acs_pkg.sv
package acs_pkg;

	// Field widths
	localparam int unsigned CP_W = 21;
	localparam int unsigned FORM_W = 16;

	// Mark buffer sizing: MAX_MARKS is clipped to the physical depth
	localparam int unsigned MAX_MARKS = 8;
	localparam int unsigned MARK_DEPTH = 8;
	localparam int unsigned MARK_CAP = (MAX_MARKS < MARK_DEPTH) ? MAX_MARKS : MARK_DEPTH;
	localparam int unsigned MIDX_W = $clog2(MARK_DEPTH);
	localparam int unsigned MCNT_W = $clog2(MARK_DEPTH + 1);
	// One item gives a letter, its marks and one more character at most
	localparam int unsigned SEQ_W = $clog2(MARK_DEPTH + 2);

	// Special characters
	localparam logic [CP_W-1:0] CH_LAM = 21'h000644;
	localparam logic [CP_W-1:0] CH_TATWEEL = 21'h000640;
	localparam logic [CP_W-1:0] CH_ALEF = 21'h000627;
	localparam logic [CP_W-1:0] CH_ALEF_MADDA = 21'h000622;
	localparam logic [CP_W-1:0] CH_ALEF_HAMZA_ABOVE = 21'h000623;
	localparam logic [CP_W-1:0] CH_ALEF_HAMZA_BELOW = 21'h000625;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic run_end;
	} in_item_t;

	typedef struct packed {
		logic [CP_W-1:0] shaped_point;
		logic last_of_burst;
		logic mark_dropped;
	} out_item_t;

	// Presentation forms of one letter; a zero form is absent
	typedef struct packed {
		logic hit;
		logic [FORM_W-1:0] iso;
		logic [FORM_W-1:0] fin;
		logic [FORM_W-1:0] ini;
		logic [FORM_W-1:0] med;
	} form_t;

	typedef struct packed {
		logic hit;
		logic [FORM_W-1:0] iso;
		logic [FORM_W-1:0] fin;
	} lig_t;

	typedef logic [MARK_DEPTH-1:0][CP_W-1:0] mark_arr_t;

	// Work for the back end: letter A, then mcount marks, then character B
	typedef struct packed {
		logic a_valid;
		logic [CP_W-1:0] a_cp;
		mark_arr_t marks;
		logic [MCNT_W-1:0] mcount;
		logic b_valid;
		logic [CP_W-1:0] b_cp;
		logic drop;
	} cmd_t;

	function automatic form_t mk_form(input logic [FORM_W-1:0] iso, input logic [FORM_W-1:0] fin,
		input logic [FORM_W-1:0] ini, input logic [FORM_W-1:0] med);
		form_t f;
		f.hit = 1'b1;
		f.iso = iso;
		f.fin = fin;
		f.ini = ini;
		f.med = med;
		return f;
	endfunction

	function automatic form_t form_lookup(input logic [CP_W-1:0] cp);
		form_t f;
		f = '0;
		case (cp)
			21'h000621: f = mk_form(16'hFE80, 16'h0000, 16'h0000, 16'h0000);
			21'h000622: f = mk_form(16'hFE81, 16'hFE82, 16'h0000, 16'h0000);
			21'h000623: f = mk_form(16'hFE83, 16'hFE84, 16'h0000, 16'h0000);
			21'h000624: f = mk_form(16'hFE85, 16'hFE86, 16'h0000, 16'h0000);
			21'h000625: f = mk_form(16'hFE87, 16'hFE88, 16'h0000, 16'h0000);
			21'h000626: f = mk_form(16'hFE89, 16'hFE8A, 16'hFE8B, 16'hFE8C);
			21'h000627: f = mk_form(16'hFE8D, 16'hFE8E, 16'h0000, 16'h0000);
			21'h000628: f = mk_form(16'hFE8F, 16'hFE90, 16'hFE91, 16'hFE92);
			21'h000629: f = mk_form(16'hFE93, 16'hFE94, 16'h0000, 16'h0000);
			21'h00062A: f = mk_form(16'hFE95, 16'hFE96, 16'hFE97, 16'hFE98);
			21'h00062B: f = mk_form(16'hFE99, 16'hFE9A, 16'hFE9B, 16'hFE9C);
			21'h00062C: f = mk_form(16'hFE9D, 16'hFE9E, 16'hFE9F, 16'hFEA0);
			21'h00062D: f = mk_form(16'hFEA1, 16'hFEA2, 16'hFEA3, 16'hFEA4);
			21'h00062E: f = mk_form(16'hFEA5, 16'hFEA6, 16'hFEA7, 16'hFEA8);
			21'h00062F: f = mk_form(16'hFEA9, 16'hFEAA, 16'h0000, 16'h0000);
			21'h000630: f = mk_form(16'hFEAB, 16'hFEAC, 16'h0000, 16'h0000);
			21'h000631: f = mk_form(16'hFEAD, 16'hFEAE, 16'h0000, 16'h0000);
			21'h000632: f = mk_form(16'hFEAF, 16'hFEB0, 16'h0000, 16'h0000);
			21'h000633: f = mk_form(16'hFEB1, 16'hFEB2, 16'hFEB3, 16'hFEB4);
			21'h000634: f = mk_form(16'hFEB5, 16'hFEB6, 16'hFEB7, 16'hFEB8);
			21'h000635: f = mk_form(16'hFEB9, 16'hFEBA, 16'hFEBB, 16'hFEBC);
			21'h000636: f = mk_form(16'hFEBD, 16'hFEBE, 16'hFEBF, 16'hFEC0);
			21'h000637: f = mk_form(16'hFEC1, 16'hFEC2, 16'hFEC3, 16'hFEC4);
			21'h000638: f = mk_form(16'hFEC5, 16'hFEC6, 16'hFEC7, 16'hFEC8);
			21'h000639: f = mk_form(16'hFEC9, 16'hFECA, 16'hFECB, 16'hFECC);
			21'h00063A: f = mk_form(16'hFECD, 16'hFECE, 16'hFECF, 16'hFED0);
			21'h000641: f = mk_form(16'hFED1, 16'hFED2, 16'hFED3, 16'hFED4);
			21'h000642: f = mk_form(16'hFED5, 16'hFED6, 16'hFED7, 16'hFED8);
			21'h000643: f = mk_form(16'hFED9, 16'hFEDA, 16'hFEDB, 16'hFEDC);
			21'h000644: f = mk_form(16'hFEDD, 16'hFEDE, 16'hFEDF, 16'hFEE0);
			21'h000645: f = mk_form(16'hFEE1, 16'hFEE2, 16'hFEE3, 16'hFEE4);
			21'h000646: f = mk_form(16'hFEE5, 16'hFEE6, 16'hFEE7, 16'hFEE8);
			21'h000647: f = mk_form(16'hFEE9, 16'hFEEA, 16'hFEEB, 16'hFEEC);
			21'h000648: f = mk_form(16'hFEED, 16'hFEEE, 16'h0000, 16'h0000);
			21'h000649: f = mk_form(16'hFEEF, 16'hFEF0, 16'h0000, 16'h0000);
			21'h00064A: f = mk_form(16'hFEF1, 16'hFEF2, 16'hFEF3, 16'hFEF4);
			21'h00067E: f = mk_form(16'hFB56, 16'hFB57, 16'hFB58, 16'hFB59);
			21'h000686: f = mk_form(16'hFB7A, 16'hFB7B, 16'hFB7C, 16'hFB7D);
			21'h000698: f = mk_form(16'hFB8A, 16'hFB8B, 16'h0000, 16'h0000);
			21'h0006AF: f = mk_form(16'hFB92, 16'hFB93, 16'hFB94, 16'hFB95);
			21'h0006BE: f = mk_form(16'hFBAA, 16'hFBAB, 16'hFBAC, 16'hFBAD);
			21'h0006C1: f = mk_form(16'hFBA6, 16'hFBA7, 16'hFBA8, 16'hFBA9);
			21'h0006CC: f = mk_form(16'hFBFC, 16'hFBFD, 16'hFBFE, 16'hFBFF);
			21'h0006D2: f = mk_form(16'hFBAE, 16'hFBAF, 16'h0000, 16'h0000);
			default: f = '0;
		endcase
		return f;
	endfunction

	// Lam-alef ligatures keyed by the alef variant
	function automatic lig_t lig_lookup(input logic [CP_W-1:0] cp);
		lig_t l;
		l = '0;
		case (cp)
			CH_ALEF: l = {1'b1, 16'hFEFB, 16'hFEFC};
			CH_ALEF_MADDA: l = {1'b1, 16'hFEF5, 16'hFEF6};
			CH_ALEF_HAMZA_ABOVE: l = {1'b1, 16'hFEF7, 16'hFEF8};
			CH_ALEF_HAMZA_BELOW: l = {1'b1, 16'hFEF9, 16'hFEFA};
			default: l = '0;
		endcase
		return l;
	endfunction

	// Transparent combining marks
	function automatic logic is_mark(input logic [CP_W-1:0] cp);
		return (cp >= 21'h00064B && cp <= 21'h000652) || cp == 21'h000670 ||
			(cp >= 21'h0006D6 && cp <= 21'h0006DC) || (cp >= 21'h0006DF && cp <= 21'h0006E4) ||
			(cp >= 21'h0006E7 && cp <= 21'h0006E8) || (cp >= 21'h0006EA && cp <= 21'h0006ED);
	endfunction

	// Contextual form choice; the isolated form is always present
	function automatic logic [CP_W-1:0] pick_form(input form_t f, input logic join_prev,
		input logic join_next);
		logic [FORM_W-1:0] v;
		v = f.iso;
		if (join_prev && join_next) begin
			v = (f.med != '0) ? f.med : ((f.fin != '0) ? f.fin : f.iso);
		end else if (join_prev) begin
			v = (f.fin != '0) ? f.fin : f.iso;
		end else if (join_next) begin
			v = (f.ini != '0) ? f.ini : f.iso;
		end
		return {{(CP_W-FORM_W){1'b0}}, v};
	endfunction

endpackage

### design/acs_front.sv
module acs_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input acs_pkg::in_item_t item,
	output logic cmd_push,
	output acs_pkg::cmd_t cmd,
	input logic cmd_full
);
	import acs_pkg::*;

	logic prev_q;
	logic pend_valid_q;
	logic pend_lam_q;
	form_t pend_form_q;
	mark_arr_t marks_q;
	logic [MCNT_W-1:0] mcount_q;
	logic drop_q;

	logic acc;
	logic [CP_W-1:0] cp;
	form_t f;
	lig_t lg;
	logic mk;
	logic jb_cp;

	logic n_prev, n_pend_valid, n_pend_lam, n_drop, append, flush, a_valid, b_valid;
	form_t n_pend_form;
	logic [CP_W-1:0] a_cp, b_cp;
	logic [MCNT_W-1:0] snap_count;
	mark_arr_t snap_marks;

	assign full = cmd_full;
	assign acc = push && !cmd_full;
	assign cp = item.code_point;
	assign f = form_lookup(cp);
	assign lg = lig_lookup(cp);
	assign mk = is_mark(cp);
	assign jb_cp = (cp == CH_TATWEEL) || (f.hit && (f.fin != '0 || f.med != '0));

	// Classify the item and work out the next state and the emit list
	always_comb begin
		n_prev = prev_q;
		n_pend_valid = pend_valid_q;
		n_pend_lam = pend_lam_q;
		n_pend_form = pend_form_q;
		n_drop = drop_q;
		append = 1'b0;
		flush = 1'b0;
		a_valid = 1'b0;
		a_cp = '0;
		b_valid = 1'b0;
		b_cp = cp;
		if (mk) begin
			if (pend_valid_q) begin
				if (mcount_q < MCNT_W'(MARK_CAP)) begin
					append = 1'b1;
				end else begin
					n_drop = 1'b1;
				end
			end else begin
				b_valid = 1'b1;
			end
		end else begin
			if (pend_valid_q) begin
				a_valid = 1'b1;
				flush = 1'b1;
				n_pend_valid = 1'b0;
				if (pend_lam_q && lg.hit) begin
					a_cp = {{(CP_W-FORM_W){1'b0}}, (prev_q ? lg.fin : lg.iso)};
					n_prev = 1'b0;
				end else begin
					a_cp = pick_form(pend_form_q, prev_q, jb_cp);
					n_prev = (pend_form_q.ini != '0) || (pend_form_q.med != '0);
				end
			end
			if (!(pend_valid_q && pend_lam_q && lg.hit)) begin
				if (f.hit) begin
					n_pend_valid = 1'b1;
					n_pend_lam = (cp == CH_LAM);
					n_pend_form = f;
				end else begin
					b_valid = 1'b1;
					n_prev = (cp == CH_TATWEEL);
				end
			end
		end
		// Run end flushes whatever is held
		if (item.run_end) begin
			if (n_pend_valid) begin
				if (mk) begin
					a_valid = 1'b1;
					a_cp = pick_form(pend_form_q, prev_q, 1'b0);
					flush = 1'b1;
				end else begin
					b_valid = 1'b1;
					b_cp = pick_form(f, n_prev, 1'b0);
				end
			end
			n_pend_valid = 1'b0;
			n_prev = 1'b0;
		end
	end

	// Snapshot of the mark buffer including a mark taken this cycle
	always_comb begin
		snap_marks = marks_q;
		if (append) begin
			snap_marks[mcount_q[MIDX_W-1:0]] = cp;
		end
		snap_count = mcount_q + MCNT_W'(append);
	end

	assign cmd_push = acc && (a_valid || b_valid);
	always_comb begin
		cmd.a_valid = a_valid;
		cmd.a_cp = a_cp;
		cmd.marks = snap_marks;
		cmd.mcount = flush ? snap_count : '0;
		cmd.b_valid = b_valid;
		cmd.b_cp = b_cp;
		cmd.drop = n_drop;
	end

	// Shaping state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_lam_q <= 1'b0;
			mcount_q <= '0;
			drop_q <= 1'b0;
		end else if (acc) begin
			prev_q <= n_prev;
			pend_valid_q <= n_pend_valid;
			pend_lam_q <= n_pend_lam;
			mcount_q <= (flush || item.run_end) ? '0 : snap_count;
			drop_q <= (a_valid || b_valid) ? 1'b0 : n_drop;
		end
	end

	// Payload: held letter forms and buffered marks
	always_ff @(posedge clk) begin
		if (acc) begin
			pend_form_q <= n_pend_form;
			marks_q <= snap_marks;
		end
	end

endmodule

### design/acs_cmd_queue.sv
module acs_cmd_queue (
	input logic clk,
	input logic arst_n,
	input logic wr,
	input acs_pkg::cmd_t wdata,
	output logic full,
	output logic valid,
	output acs_pkg::cmd_t rdata,
	input logic rd
);
	import acs_pkg::*;

	cmd_t ent_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign rdata = ent_q[rp_q];

	// Two-entry queue between classification and emission
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr && !full) wp_q <= !wp_q;
			if (rd && valid) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr && !full) - 2'(rd && valid);
		end
	end

	always_ff @(posedge clk) begin
		if (wr && !full) ent_q[wp_q] <= wdata;
	end

endmodule

### design/acs_back.sv
module acs_back (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input acs_pkg::cmd_t cmd,
	output logic cmd_pop,
	output logic empty,
	input logic pop,
	output acs_pkg::out_item_t result
);
	import acs_pkg::*;

	logic [SEQ_W-1:0] k_q;
	logic [SEQ_W-1:0] a_off, j, total;
	logic last, emit, ofull;
	logic [CP_W-1:0] sel_cp;
	out_item_t wr_item;

	out_item_t ent_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	// Pick the element of the burst at position k
	always_comb begin
		a_off = SEQ_W'(cmd.a_valid);
		j = k_q - a_off;
		total = a_off + SEQ_W'(cmd.mcount) + SEQ_W'(cmd.b_valid);
		last = (k_q == total - SEQ_W'(1));
		if (cmd.a_valid && k_q == '0) begin
			sel_cp = cmd.a_cp;
		end else if (j < SEQ_W'(cmd.mcount)) begin
			sel_cp = cmd.marks[j[MIDX_W-1:0]];
		end else begin
			sel_cp = cmd.b_cp;
		end
		wr_item.shaped_point = sel_cp;
		wr_item.last_of_burst = last;
		wr_item.mark_dropped = cmd.drop;
	end

	assign ofull = (cnt_q == 2'd2);
	assign emit = cmd_valid && !ofull;
	assign cmd_pop = emit && last;

	// Burst position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (emit) begin
			k_q <= last ? '0 : k_q + SEQ_W'(1);
		end
	end

	// Result queue: keeps emission going while the consumer stalls
	assign empty = (cnt_q == 2'd0);
	assign result = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (emit) wp_q <= !wp_q;
			if (pop && !empty) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(emit) - 2'(pop && !empty);
		end
	end

	always_ff @(posedge clk) begin
		if (emit) ent_q[wp_q] <= wr_item;
	end

endmodule

### design/arabic_contextual_shaper_core.sv
// Arabic contextual shaper. Code points of one right-to-left run go in, in
// logical order, through push/full; shaped code points come out through
// empty/pop, with last_of_burst on the final result of each item and
// mark_dropped on every result of a burst after a mark overflow. An item is
// taken each cycle while the two-entry command queue has room; the emitter
// then writes the results of each item one by one into the result queue, and
// an item gives 0 to 10 results (about 1 to 2 per character for ordinary
// text). A held letter appears only once the next non-mark arrives or the
// run ends.
module arabic_contextual_shaper_core (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input acs_pkg::in_item_t item,
	output logic empty,
	input logic pop,
	output acs_pkg::out_item_t result
);
	import acs_pkg::*;

	logic cmd_push, cmd_full, cmd_valid, cmd_pop;
	cmd_t cmd_in, cmd_out;

	// Front end: classification and shaping state
	acs_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.cmd_push(cmd_push),
		.cmd(cmd_in),
		.cmd_full(cmd_full)
	);

	acs_cmd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr(cmd_push),
		.wdata(cmd_in),
		.full(cmd_full),
		.valid(cmd_valid),
		.rdata(cmd_out),
		.rd(cmd_pop)
	);

	// Back end: serialises each burst
	acs_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd(cmd_out),
		.cmd_pop(cmd_pop),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

endmodule

### design/acs_checker.sv
module acs_checker (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input acs_pkg::out_item_t result
);
	import acs_pkg::*;

	// A burst continues right after a non-final result is taken
	a_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !result.last_of_burst) |=> !empty)
		else $error("burst broken after non-final item");

	// The drop flag is the same across one burst
	a_drop_const: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !result.last_of_burst) |=>
		(result.mark_dropped == $past(result.mark_dropped)))
		else $error("mark_dropped changed inside a burst");

	// A waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed");

endmodule

bind arabic_contextual_shaper_core acs_checker u_acs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.empty(empty),
	.pop(pop),
	.result(result)
);
